// ===== hdl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master package
// Request and response payload types, command codes, status codes and
// configuration register indexes shared by the controller and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

   // Width of the configuration write data (widest register).
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_DELAY    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_CYCLE    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd80;
   localparam logic [23:0] SETUP_DELAY_RESET    = 24'd1000;
   localparam logic [23:0] WRITE_CYCLE_RESET    = 24'd12000;

   // Request command codes.
   localparam logic [1:0] CMD_TICK        = 2'd0;
   localparam logic [1:0] CMD_START_WRITE = 2'd1;
   localparam logic [1:0] CMD_START_READ  = 2'd2;
   localparam logic [1:0] CMD_QUEUE_BYTE  = 2'd3;

   // Completion status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BUS_BUSY = 2'd1;
   localparam logic [1:0] ST_BUS_ERR  = 2'd2;
   localparam logic [1:0] ST_ADDR_NAK = 2'd3;

   // One request: a quarter-bit tick with an optional command.
   typedef struct packed {
      logic [1:0]  command;
      logic        sda_in;
      logic [15:0] mem_address;
      logic [6:0]  byte_count;
      logic [7:0]  write_data;
   } req_type;

   // One response: pin drive levels and status for one tick.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       write_enable;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic [1:0] status;
      logic       busy_res;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/i2cee_wbuf.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM write buffer
// Page-write byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_wbuf #(
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [7:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [7:0]                             rd_data
);

   logic [7:0] mem [0:DEPTH-1];
   logic [7:0] rd_data_ff;

   // Write port; contents are only read where written since the last clear.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, refreshed every cycle at the current read address.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/i2c_eeprom_master_controller.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master controller
// Bit-level I2C master for a 24Cxx EEPROM with 16-bit word addresses.
//
// Each request on the req_ channel is one quarter-bit bus tick. It carries
// the sampled SDA level and a command: plain tick, start a page write of the
// queued bytes, start a sequential read, or queue one write byte.
// Each accepted request yields exactly one response on the rsp_ channel with
// the SCL and SDA drive levels, the write-protect release, a received byte
// with its valid and last markers, and completion status.
// The state machine advances once per request and its response is registered
// in the cycle after acceptance; one request is taken every cycle unless a
// response is held. While a response is held by rsp_stall, req_stall is
// raised and the state does not move; the response stays stable until taken.
// The csr_ port writes the device address, the set-up delay and the
// write-cycle delay in ticks; write it only while the block is idle.
// Reset returns the controller to idle with an empty write buffer and the
// default register values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_master_controller #(
   parameter int BUFFER_DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire i2cee_pkg::req_type                req_payload,
   // Response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output i2cee_pkg::rsp_type                     rsp_payload,
   // Configuration port
   input  wire logic                              csr_wr_en,
   input  wire logic [i2cee_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [i2cee_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FW = $clog2(BUFFER_DEPTH + 1);
   localparam int CW = (FW > 7) ? FW : 7;

   typedef enum logic [4:0] {
      PH_IDLE, PH_SETUP, PH_WSTART, PH_WDEV, PH_WAH, PH_WAL, PH_WDATA,
      PH_WSTOP, PH_WCYCLE, PH_WNSTOP, PH_RSTART, PH_RDEV, PH_RAH, PH_RAL,
      PH_RRESTART, PH_RDEVR, PH_RRECV, PH_RSTOP, PH_RNSTOP
   } phase_type;

   // Phases that belong to a page write.
   function automatic logic is_write(input phase_type ph);
      logic w;
      case (ph)
         PH_SETUP, PH_WSTART, PH_WDEV, PH_WAH, PH_WAL, PH_WDATA,
         PH_WSTOP, PH_WCYCLE, PH_WNSTOP: w = 1'b1;
         default: w = 1'b0;
      endcase
      return w;
   endfunction

   // Configuration registers.
   logic [6:0]  dev_addr_ff;
   logic [23:0] setup_ff;
   logic [23:0] wcyc_ff;

   // Controller state.
   phase_type   phase_ff, phase_in;
   logic [1:0]  qstep_ff, qstep_in;
   logic [3:0]  bitcnt_ff, bitcnt_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] waddr_ff, waddr_in;
   logic [CW-1:0] left_ff, left_in;
   logic [23:0] wait_ff, wait_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [IW-1:0] rdidx_ff, rdidx_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   i2cee_pkg::rsp_type      rsp_ff, rsp_in;

   // Write buffer access.
   logic       buf_we;
   logic [7:0] buf_q;

   logic       req_accept;
   logic       was_write;
   logic [7:0] dev;
   logic       done;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign dev        = {dev_addr_ff, 1'b0};
   assign was_write  = is_write(phase_ff);

   i2cee_wbuf #(
      .DEPTH (BUFFER_DEPTH)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (fill_ff[IW-1:0]),
      .wr_data (req_payload.write_data),
      .rd_addr (rdidx_ff),
      .rd_data (buf_q)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cee_pkg::DEVICE_ADDRESS_RESET;
         setup_ff    <= i2cee_pkg::SETUP_DELAY_RESET;
         wcyc_ff     <= i2cee_pkg::WRITE_CYCLE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            i2cee_pkg::CSR_DEVICE_ADDRESS: dev_addr_ff <= csr_wdata[6:0];
            i2cee_pkg::CSR_SETUP_DELAY:    setup_ff    <= csr_wdata[23:0];
            i2cee_pkg::CSR_WRITE_CYCLE:    wcyc_ff     <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // One tick of the bus state machine.
   always_comb begin
      phase_in  = phase_ff;
      qstep_in  = qstep_ff;
      bitcnt_in = bitcnt_ff;
      shift_in  = shift_ff;
      waddr_in  = waddr_ff;
      left_in   = left_ff;
      wait_in   = wait_ff;
      fill_in   = fill_ff;
      rdidx_in  = rdidx_ff;
      buf_we    = 1'b0;
      done      = 1'b0;
      rsp_in    = '0;
      rsp_in.scl_level = 1'b1;
      rsp_in.sda_level = 1'b1;
      rsp_in.status    = i2cee_pkg::ST_OK;

      if (req_accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_payload.command == i2cee_pkg::CMD_START_WRITE) begin
                  waddr_in = req_payload.mem_address;
                  left_in  = CW'(fill_ff);
                  rdidx_in = '0;
                  wait_in  = setup_ff;
                  phase_in = PH_SETUP;
               end else if (req_payload.command == i2cee_pkg::CMD_START_READ) begin
                  waddr_in = req_payload.mem_address;
                  left_in  = (req_payload.byte_count == 7'd0) ? CW'(1)
                                                              : CW'(req_payload.byte_count);
                  phase_in = PH_RSTART;
                  qstep_in = 2'd0;
               end else if (req_payload.command == i2cee_pkg::CMD_QUEUE_BYTE &&
                            fill_ff < FW'(BUFFER_DEPTH)) begin
                  buf_we  = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end

            PH_SETUP: begin
               if (wait_ff == 24'd0) begin
                  phase_in = PH_WSTART;
                  qstep_in = 2'd0;
               end else begin
                  wait_in = wait_ff - 24'd1;
               end
            end

            // Start condition with bus check.
            PH_WSTART, PH_RSTART: begin
               if (qstep_ff == 2'd0) begin
                  if (!req_payload.sda_in) begin
                     done          = 1'b1;
                     rsp_in.status = i2cee_pkg::ST_BUS_BUSY;
                  end else begin
                     qstep_in = 2'd1;
                  end
               end else if (qstep_ff == 2'd1) begin
                  rsp_in.sda_level = 1'b0;
                  if (req_payload.sda_in) begin
                     done          = 1'b1;
                     rsp_in.status = i2cee_pkg::ST_BUS_ERR;
                  end else begin
                     qstep_in = 2'd2;
                  end
               end else begin
                  rsp_in.scl_level = 1'b0;
                  rsp_in.sda_level = 1'b0;
                  phase_in  = (phase_ff == PH_WSTART) ? PH_WDEV : PH_RDEV;
                  shift_in  = dev;
                  bitcnt_in = 4'd0;
                  qstep_in  = 2'd0;
               end
            end

            // Repeated start after the word address, before the read device byte.
            PH_RRESTART: begin
               rsp_in.scl_level = (qstep_ff == 2'd1) || (qstep_ff == 2'd2);
               rsp_in.sda_level = (qstep_ff <= 2'd1);
               if (qstep_ff == 2'd3) begin
                  phase_in  = PH_RDEVR;
                  shift_in  = dev | 8'h01;
                  bitcnt_in = 4'd0;
                  qstep_in  = 2'd0;
               end else begin
                  qstep_in = qstep_ff + 2'd1;
               end
            end

            // Receive a byte, then ACK it or NACK the last one.
            PH_RRECV: begin
               rsp_in.scl_level = (qstep_ff == 2'd1) || (qstep_ff == 2'd2);
               rsp_in.sda_level = !bitcnt_ff[3] ? 1'b1 : !(left_ff > CW'(1));
               if (qstep_ff == 2'd2 && !bitcnt_ff[3]) begin
                  shift_in = {shift_ff[6:0], req_payload.sda_in};
                  if (bitcnt_ff == 4'd7) begin
                     rsp_in.read_valid = 1'b1;
                     rsp_in.read_data  = {shift_ff[6:0], req_payload.sda_in};
                     rsp_in.read_last  = (left_ff <= CW'(1));
                  end
               end
               if (qstep_ff == 2'd3) begin
                  if (bitcnt_ff[3]) begin
                     if (left_ff > CW'(1)) begin
                        left_in   = left_ff - CW'(1);
                        bitcnt_in = 4'd0;
                        qstep_in  = 2'd0;
                     end else begin
                        phase_in = PH_RSTOP;
                        qstep_in = 2'd0;
                     end
                  end else begin
                     bitcnt_in = bitcnt_ff + 4'd1;
                     qstep_in  = 2'd0;
                  end
               end else begin
                  qstep_in = qstep_ff + 2'd1;
               end
            end

            // Stop condition.
            PH_WSTOP, PH_RSTOP, PH_WNSTOP, PH_RNSTOP: begin
               rsp_in.scl_level = (qstep_ff >= 2'd1);
               rsp_in.sda_level = (qstep_ff >= 2'd2);
               if (qstep_ff >= 2'd2) begin
                  if (phase_ff == PH_WSTOP) begin
                     phase_in = PH_WCYCLE;
                     wait_in  = wcyc_ff;
                     qstep_in = 2'd0;
                  end else begin
                     done          = 1'b1;
                     rsp_in.status = (phase_ff == PH_RSTOP) ? i2cee_pkg::ST_OK
                                                            : i2cee_pkg::ST_ADDR_NAK;
                  end
               end else begin
                  qstep_in = qstep_ff + 2'd1;
               end
            end

            PH_WCYCLE: begin
               if (wait_ff == 24'd0) begin
                  done = 1'b1;
               end else begin
                  wait_in = wait_ff - 24'd1;
               end
            end

            // Send a byte and sample its acknowledge.
            PH_WDEV, PH_WAH, PH_WAL, PH_WDATA, PH_RDEV, PH_RAH, PH_RAL,
            PH_RDEVR: begin
               rsp_in.scl_level = (qstep_ff == 2'd1) || (qstep_ff == 2'd2);
               rsp_in.sda_level = !bitcnt_ff[3] ? shift_ff[~bitcnt_ff[2:0]] : 1'b1;
               if (qstep_ff == 2'd2 && bitcnt_ff[3]) begin
                  shift_in = {7'd0, req_payload.sda_in};
               end
               if (qstep_ff == 2'd3) begin
                  if (bitcnt_ff[3]) begin
                     bitcnt_in = 4'd0;
                     qstep_in  = 2'd0;
                     case (phase_ff)
                        PH_WDEV, PH_RDEV: begin
                           if (shift_ff != 8'd0) begin
                              phase_in = (phase_ff == PH_WDEV) ? PH_WNSTOP : PH_RNSTOP;
                              bitcnt_in = bitcnt_ff;
                           end else begin
                              phase_in = (phase_ff == PH_WDEV) ? PH_WAH : PH_RAH;
                              shift_in = waddr_ff[15:8];
                           end
                        end
                        PH_WAH: begin
                           phase_in = PH_WAL;
                           shift_in = waddr_ff[7:0];
                        end
                        PH_RAH: begin
                           phase_in = PH_RAL;
                           shift_in = waddr_ff[7:0];
                        end
                        PH_WAL, PH_WDATA: begin
                           if (left_ff != CW'(0)) begin
                              phase_in = PH_WDATA;
                              shift_in = buf_q;
                              left_in  = left_ff - CW'(1);
                              rdidx_in = (rdidx_ff == IW'(BUFFER_DEPTH - 1)) ? '0
                                                                              : rdidx_ff + IW'(1);
                           end else begin
                              phase_in  = PH_WSTOP;
                              bitcnt_in = bitcnt_ff;
                           end
                        end
                        PH_RAL: begin
                           phase_in  = PH_RRESTART;
                           bitcnt_in = bitcnt_ff;
                        end
                        default: begin
                           phase_in = PH_RRECV;
                           shift_in = 8'd0;
                        end
                     endcase
                  end else begin
                     bitcnt_in = bitcnt_ff + 4'd1;
                     qstep_in  = 2'd0;
                  end
               end else begin
                  qstep_in = qstep_ff + 2'd1;
               end
            end

            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // End of a transaction: back to idle, empty the buffer after a write.
         if (done) begin
            phase_in  = PH_IDLE;
            qstep_in  = 2'd0;
            bitcnt_in = 4'd0;
            if (was_write) begin
               fill_in  = '0;
               rdidx_in = '0;
            end
         end
      end

      rsp_in.done_res     = done;
      rsp_in.write_enable = is_write(phase_in);
      rsp_in.busy_res     = (phase_in != PH_IDLE);

      // Response register handshake.
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         qstep_ff     <= 2'd0;
         bitcnt_ff    <= 4'd0;
         shift_ff     <= 8'd0;
         waddr_ff     <= 16'd0;
         left_ff      <= '0;
         wait_ff      <= 24'd0;
         fill_ff      <= '0;
         rdidx_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         qstep_ff     <= qstep_in;
         bitcnt_ff    <= bitcnt_in;
         shift_ff     <= shift_in;
         waddr_ff     <= waddr_in;
         left_ff      <= left_in;
         wait_ff      <= wait_in;
         fill_ff      <= fill_in;
         rdidx_ff     <= rdidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload is held while stalled.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== sim/tb_i2c_eeprom_master_controller.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master controller testbench
// Drives quarter-bit bus ticks into the controller with sampled SDA levels
// chosen from the predicted bus state. This steers transfers through clean
// acknowledges, busy and broken buses, address NACKs and random line noise.
// Every tick response is checked field by field against an in-bench model
// of the controller. A scripted run covers the edge cases first, then
// random transfers run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_master_controller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_DEPTH  = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int TOTAL_ITEMS = 1150;
   localparam int REGIMES     = 3;
   localparam int FAST_ROW    = 6;

   // Bus phases of the in-bench model; the write phases form one range.
   typedef enum logic [4:0] {
      PH_IDLE, PH_SETUP, PH_WSTART, PH_WDEV, PH_WAH, PH_WAL, PH_WDATA,
      PH_WSTOP, PH_WCYCLE, PH_WNSTOP, PH_RSTART, PH_RDEV, PH_RAH, PH_RAL,
      PH_RRESTART, PH_RDEVR, PH_RRECV, PH_RSTOP, PH_RNSTOP
   } bus_phase_type;

   // How the sampled SDA level answers the master during a transfer.
   typedef enum logic [2:0] {
      SDA_GOOD, SDA_BUSY, SDA_ERROR, SDA_NACK, SDA_NOISE
   } sda_mode_type;

   // One line of the scripted run.
   typedef struct packed {
      logic [1:0]   cmd;
      logic [6:0]   rep;
      logic [15:0]  addr;
      logic [6:0]   cnt;
      logic [7:0]   data;
      sda_mode_type mode;
      logic         has_want;
      logic [1:0]   want;
   } script_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   i2cee_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   i2cee_pkg::rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [i2cee_pkg::CSR_INDEX_W-1:0] csr_index = i2cee_pkg::CSR_DEVICE_ADDRESS;
   logic [i2cee_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Model state and registers.
   bus_phase_type ph;
   logic [1:0]  qstep;
   logic [3:0]  bit_no;
   logic [7:0]  shreg;
   logic [15:0] word_addr;
   logic [6:0]  left;
   logic [23:0] wait_cnt;
   logic [7:0]  page_buf [PAGE_DEPTH];
   logic [6:0]  fill;
   logic [5:0]  rd_idx;
   logic [6:0]  dev_addr;
   logic [23:0] setup_ticks;
   logic [23:0] cycle_ticks;

   i2cee_pkg::rsp_type pending_ticks [$];
   int snd_pct = 18;
   int rcv_pct = 66;
   int errors = 0;
   int sent_count = 0;
   int rsp_count = 0;
   int quiet_cycles = 0;
   logic done_seen = 1'b0;
   logic [1:0] last_status = i2cee_pkg::ST_OK;

   script_row_type script [15] = '{
      '{i2cee_pkg::CMD_START_READ, 7'd1, 16'h0000, 7'd1, 8'h00, SDA_BUSY,
        1'b1, i2cee_pkg::ST_BUS_BUSY},
      '{i2cee_pkg::CMD_START_READ, 7'd1, 16'h0000, 7'd1, 8'h00, SDA_ERROR,
        1'b1, i2cee_pkg::ST_BUS_ERR},
      '{i2cee_pkg::CMD_START_READ, 7'd1, 16'hFFFF, 7'd3, 8'h00, SDA_NACK,
        1'b1, i2cee_pkg::ST_ADDR_NAK},
      '{i2cee_pkg::CMD_START_READ, 7'd1, 16'hFFFF, 7'd0, 8'h00, SDA_GOOD,
        1'b1, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_QUEUE_BYTE, 7'd2, 16'h0000, 7'd0, 8'hFF, SDA_GOOD,
        1'b0, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_START_READ, 7'd1, 16'h00FF, 7'd2, 8'h00, SDA_GOOD,
        1'b1, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_START_WRITE, 7'd1, 16'hFFC0, 7'd0, 8'h00, SDA_GOOD,
        1'b1, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_QUEUE_BYTE, 7'd66, 16'h0000, 7'd0, 8'h80, SDA_GOOD,
        1'b0, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_START_WRITE, 7'd1, 16'h4321, 7'd0, 8'h00, SDA_NACK,
        1'b1, i2cee_pkg::ST_ADDR_NAK},
      '{i2cee_pkg::CMD_QUEUE_BYTE, 7'd1, 16'h0000, 7'd0, 8'hA5, SDA_GOOD,
        1'b0, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_START_WRITE, 7'd1, 16'h0F0F, 7'd0, 8'h00, SDA_BUSY,
        1'b1, i2cee_pkg::ST_BUS_BUSY},
      '{i2cee_pkg::CMD_QUEUE_BYTE, 7'd2, 16'h0000, 7'd0, 8'h7E, SDA_GOOD,
        1'b0, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_START_WRITE, 7'd1, 16'hF0F0, 7'd0, 8'h00, SDA_ERROR,
        1'b1, i2cee_pkg::ST_BUS_ERR},
      '{i2cee_pkg::CMD_START_WRITE, 7'd1, 16'h8000, 7'd0, 8'h00, SDA_GOOD,
        1'b1, i2cee_pkg::ST_OK},
      '{i2cee_pkg::CMD_TICK, 7'd3, 16'h0000, 7'd0, 8'h00, SDA_GOOD,
        1'b0, i2cee_pkg::ST_OK}
   };

   i2c_eeprom_master_controller uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Prints one line per mismatch and counts it.
   task automatic note_field(string what, int got, int want_v);
      if (got != want_v) begin
         errors++;
         $display("MISMATCH at response %0d, %s: got %0h, expected %0h",
                  rsp_count, what, got, want_v);
      end
   endtask

   function automatic logic is_write_phase(bus_phase_type p);
      return (p >= PH_SETUP) && (p <= PH_WNSTOP);
   endfunction

   function automatic void load_byte(bus_phase_type nxt, logic [7:0] value);
      ph = nxt;
      shreg = value;
      bit_no = 4'd0;
      qstep = 2'd0;
   endfunction

   // After the word address or a data byte: next queued byte, or STOP.
   function automatic void next_page_byte();
      logic [7:0] v;
      if (left > 0) begin
         v = page_buf[rd_idx];
         rd_idx = rd_idx + 6'd1;
         left = left - 7'd1;
         load_byte(PH_WDATA, v);
      end else begin
         ph = PH_WSTOP;
         qstep = 2'd0;
      end
   endfunction

   function automatic void reset_model();
      dev_addr = i2cee_pkg::DEVICE_ADDRESS_RESET;
      setup_ticks = i2cee_pkg::SETUP_DELAY_RESET;
      cycle_ticks = i2cee_pkg::WRITE_CYCLE_RESET;
      ph = PH_IDLE;
      qstep = '0;
      bit_no = '0;
      shreg = '0;
      word_addr = '0;
      left = '0;
      wait_cnt = '0;
      fill = '0;
      rd_idx = '0;
      for (int i = 0; i < PAGE_DEPTH; i++) page_buf[i] = 8'h00;
   endfunction

   // Advances the model by one bus tick and returns the tick's response.
   function automatic i2cee_pkg::rsp_type predict_tick(i2cee_pkg::req_type r);
      i2cee_pkg::rsp_type o;
      logic scl, sdo, rv, rl, done, was_wr, ack;
      logic [7:0] rd, dev;
      logic [1:0] st;
      scl = 1'b1;
      sdo = 1'b1;
      rv = 1'b0;
      rl = 1'b0;
      done = 1'b0;
      rd = 8'h00;
      st = i2cee_pkg::ST_OK;
      dev = {dev_addr, 1'b0};
      was_wr = is_write_phase(ph);
      case (ph)
         PH_IDLE: begin
            if (r.command == i2cee_pkg::CMD_START_WRITE) begin
               word_addr = r.mem_address;
               left = fill;
               rd_idx = '0;
               wait_cnt = setup_ticks;
               ph = PH_SETUP;
            end else if (r.command == i2cee_pkg::CMD_START_READ) begin
               word_addr = r.mem_address;
               left = (r.byte_count != 0) ? r.byte_count : 7'd1;
               ph = PH_RSTART;
               qstep = 2'd0;
            end else if (r.command == i2cee_pkg::CMD_QUEUE_BYTE && fill < PAGE_DEPTH) begin
               page_buf[fill[5:0]] = r.write_data;
               fill = fill + 7'd1;
            end
         end
         PH_SETUP: begin
            if (wait_cnt == 0) begin
               ph = PH_WSTART;
               qstep = 2'd0;
            end else wait_cnt = wait_cnt - 24'd1;
         end
         PH_WSTART, PH_RSTART: begin
            // START with a check for a held or stuck data line.
            if (qstep == 2'd0) begin
               if (!r.sda_in) begin
                  done = 1'b1;
                  st = i2cee_pkg::ST_BUS_BUSY;
               end else qstep = 2'd1;
            end else if (qstep == 2'd1) begin
               sdo = 1'b0;
               if (r.sda_in) begin
                  done = 1'b1;
                  st = i2cee_pkg::ST_BUS_ERR;
               end else qstep = 2'd2;
            end else begin
               scl = 1'b0;
               sdo = 1'b0;
               load_byte((ph == PH_WSTART) ? PH_WDEV : PH_RDEV, dev);
            end
         end
         PH_RRESTART: begin
            scl = (qstep == 2'd1 || qstep == 2'd2);
            sdo = (qstep <= 2'd1);
            if (qstep == 2'd3) load_byte(PH_RDEVR, dev | 8'h01);
            else qstep = qstep + 2'd1;
         end
         PH_RRECV: begin
            // Receive slot: ACK every byte but the last one.
            scl = (qstep == 2'd1 || qstep == 2'd2);
            sdo = (bit_no < 8) ? 1'b1 : ((left > 1) ? 1'b0 : 1'b1);
            if (qstep == 2'd2 && bit_no < 8) begin
               shreg = {shreg[6:0], r.sda_in};
               if (bit_no == 4'd7) begin
                  rv = 1'b1;
                  rd = shreg;
                  rl = (left <= 1);
               end
            end
            if (qstep == 2'd3) begin
               if (bit_no >= 8) begin
                  if (left > 1) begin
                     left = left - 7'd1;
                     bit_no = 4'd0;
                     qstep = 2'd0;
                  end else begin
                     ph = PH_RSTOP;
                     qstep = 2'd0;
                  end
               end else begin
                  bit_no = bit_no + 4'd1;
                  qstep = 2'd0;
               end
            end else qstep = qstep + 2'd1;
         end
         PH_WSTOP, PH_RSTOP, PH_WNSTOP, PH_RNSTOP: begin
            scl = (qstep >= 2'd1);
            sdo = (qstep >= 2'd2);
            if (qstep >= 2'd2) begin
               if (ph == PH_WSTOP) begin
                  ph = PH_WCYCLE;
                  wait_cnt = cycle_ticks;
                  qstep = 2'd0;
               end else begin
                  done = 1'b1;
                  st = (ph == PH_RSTOP) ? i2cee_pkg::ST_OK : i2cee_pkg::ST_ADDR_NAK;
               end
            end else qstep = qstep + 2'd1;
         end
         PH_WCYCLE: begin
            if (wait_cnt == 0) done = 1'b1;
            else wait_cnt = wait_cnt - 24'd1;
         end
         PH_WDEV, PH_WAH, PH_WAL, PH_WDATA, PH_RDEV, PH_RAH, PH_RAL, PH_RDEVR: begin
            // Byte send, MSB first, then the acknowledge slot.
            scl = (qstep == 2'd1 || qstep == 2'd2);
            sdo = (bit_no < 8) ? shreg[7 - bit_no] : 1'b1;
            if (qstep == 2'd2 && bit_no >= 8) shreg = {7'd0, r.sda_in};
            if (qstep == 2'd3) begin
               if (bit_no >= 8) begin
                  ack = (shreg == 8'h00);
                  case (ph)
                     PH_WDEV: begin
                        if (!ack) begin
                           ph = PH_WNSTOP;
                           qstep = 2'd0;
                        end else load_byte(PH_WAH, word_addr[15:8]);
                     end
                     PH_WAH: load_byte(PH_WAL, word_addr[7:0]);
                     PH_WAL, PH_WDATA: next_page_byte();
                     PH_RDEV: begin
                        if (!ack) begin
                           ph = PH_RNSTOP;
                           qstep = 2'd0;
                        end else load_byte(PH_RAH, word_addr[15:8]);
                     end
                     PH_RAH: load_byte(PH_RAL, word_addr[7:0]);
                     PH_RAL: begin
                        ph = PH_RRESTART;
                        qstep = 2'd0;
                     end
                     default: load_byte(PH_RRECV, 8'h00);
                  endcase
               end else begin
                  bit_no = bit_no + 4'd1;
                  qstep = 2'd0;
               end
            end else qstep = qstep + 2'd1;
         end
         default: ph = PH_IDLE;
      endcase

      // Any end of a page write empties the buffer.
      if (done) begin
         ph = PH_IDLE;
         qstep = 2'd0;
         bit_no = 4'd0;
         if (was_wr) begin
            fill = '0;
            rd_idx = '0;
         end
      end

      o.scl_level = scl;
      o.sda_level = sdo;
      o.write_enable = is_write_phase(ph);
      o.read_data = rd;
      o.read_valid = rv;
      o.read_last = rl;
      o.done_res = done;
      o.status = st;
      o.busy_res = (ph != PH_IDLE);
      return o;
   endfunction

   // Picks the SDA level for the next tick from the state it will meet.
   function automatic logic pick_sda(sda_mode_type mode);
      if (mode == SDA_NOISE) return 1'($urandom);
      if ((ph == PH_WSTART || ph == PH_RSTART) && qstep == 2'd0)
         return (mode != SDA_BUSY);
      if ((ph == PH_WSTART || ph == PH_RSTART) && qstep == 2'd1)
         return (mode == SDA_ERROR);
      if ((ph == PH_WDEV || ph == PH_RDEV) && bit_no >= 8)
         return (mode == SDA_NACK);
      return 1'($urandom);
   endfunction

   function automatic i2cee_pkg::req_type random_tick();
      i2cee_pkg::req_type r;
      r.command = i2cee_pkg::CMD_TICK;
      r.sda_in = 1'($urandom);
      r.mem_address = 16'($urandom);
      r.byte_count = 7'($urandom);
      r.write_data = 8'($urandom);
      return r;
   endfunction

   // Presents one request, waits for it to be taken, then predicts it.
   task automatic send_request(i2cee_pkg::req_type r);
      while ($urandom_range(99) < snd_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sent_count++;
      pending_ticks.push_back(predict_tick(r));
   endtask

   task automatic send_simple(logic [1:0] cmd, logic [7:0] data);
      i2cee_pkg::req_type r;
      r = random_tick();
      r.command = cmd;
      r.write_data = data;
      send_request(r);
   endtask

   // Starts a transfer and ticks it to its end; noise_pct of the ticks
   // carry a random command, which the busy controller must ignore.
   task automatic run_transfer(logic [1:0] cmd, logic [15:0] addr, logic [6:0] cnt,
                               sda_mode_type mode, int noise_pct);
      i2cee_pkg::req_type r;
      r = random_tick();
      r.command = cmd;
      r.mem_address = addr;
      r.byte_count = cnt;
      send_request(r);
      while (ph != PH_IDLE) begin
         r = random_tick();
         if ($urandom_range(99) < noise_pct) r.command = 2'($urandom);
         r.sda_in = pick_sda(mode);
         send_request(r);
      end
   endtask

   // Holds off new requests until every response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers while the controller is idle.
   task automatic load_settings(logic [6:0] dev, logic [23:0] setup, logic [23:0] cyc);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= i2cee_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata <= {17'd0, dev};
      @(posedge clock);
      csr_index <= i2cee_pkg::CSR_SETUP_DELAY;
      csr_wdata <= setup;
      @(posedge clock);
      csr_index <= i2cee_pkg::CSR_WRITE_CYCLE;
      csr_wdata <= cyc;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dev_addr = dev;
      setup_ticks = setup;
      cycle_ticks = cyc;
   endtask

   // One short random transfer, mostly well-formed, sometimes broken or noisy.
   task automatic random_transfer();
      int w, n;
      sda_mode_type mode;
      logic [6:0] cnt;
      n = $urandom_range(1);
      repeat (n) send_simple(i2cee_pkg::CMD_TICK, 8'($urandom));
      w = $urandom_range(99);
      mode = (w < 60) ? SDA_GOOD : (w < 70) ? SDA_BUSY : (w < 80) ? SDA_ERROR :
             (w < 90) ? SDA_NACK : SDA_NOISE;
      if ($urandom_range(99) < 45) begin
         n = $urandom_range(2);
         repeat (n) send_simple(i2cee_pkg::CMD_QUEUE_BYTE, 8'($urandom));
         run_transfer(i2cee_pkg::CMD_START_WRITE, 16'($urandom), 7'($urandom), mode, 4);
      end else begin
         if ($urandom_range(99) < 10)
            send_simple(i2cee_pkg::CMD_QUEUE_BYTE, 8'($urandom));
         w = $urandom_range(99);
         cnt = (w < 15) ? 7'd0 : 7'($urandom_range(2, 1));
         run_transfer(i2cee_pkg::CMD_START_READ, 16'($urandom), cnt, mode, 4);
      end
   endtask

   // Main sequence: reset, scripted rows, then random transfers.
   initial begin
      script_row_type row;
      int goal;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(script); i++) begin
         row = script[i];
         if (i == FAST_ROW) load_settings(7'h7F, 24'd2, 24'd3);
         if (row.cmd == i2cee_pkg::CMD_QUEUE_BYTE || row.cmd == i2cee_pkg::CMD_TICK) begin
            for (int k = 0; k < row.rep; k++) send_simple(row.cmd, row.data + 8'(k));
         end else begin
            done_seen = 1'b0;
            run_transfer(row.cmd, row.addr, row.cnt, row.mode,
                         (row.mode == SDA_NOISE) ? 10 : 0);
            if (row.has_want) begin
               settle();
               note_field("transfer ended", done_seen, 1);
               note_field("final status", last_status, row.want);
            end
         end
      end

      // The rest of the request budget is split over the idle patterns.
      for (int g = 0; g < REGIMES; g++) begin
         case (g)
            0: begin
               snd_pct = 18;
               rcv_pct = 66;
            end
            1: begin
               snd_pct = 66;
               rcv_pct = 18;
            end
            default: begin
               snd_pct = 0;
               rcv_pct = 0;
            end
         endcase
         case (g)
            0: load_settings(7'($urandom), 24'd0, 24'd0);
            1: load_settings(7'h00, 24'($urandom_range(3, 1)), 24'($urandom_range(3, 1)));
            default: load_settings(7'($urandom), 24'($urandom_range(2)), 24'd1);
         endcase
         goal = sent_count + (TOTAL_ITEMS - sent_count) / (REGIMES - g);
         do random_transfer(); while (sent_count < goal);
      end

      settle();
      repeat (4) @(posedge clock);
      note_field("unanswered requests", pending_ticks.size(), 0);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   // Response side: random stalls and the per-tick check.
   always @(posedge clock) begin
      i2cee_pkg::rsp_type want;
      rsp_stall <= ($urandom_range(99) < rcv_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (rsp_payload.done_res) begin
            done_seen = 1'b1;
            last_status = rsp_payload.status;
         end
         if (pending_ticks.size() == 0) begin
            note_field("response with no request", 1, 0);
         end else begin
            want = pending_ticks.pop_front();
            note_field("scl_level", rsp_payload.scl_level, want.scl_level);
            note_field("sda_level", rsp_payload.sda_level, want.sda_level);
            note_field("write_enable", rsp_payload.write_enable, want.write_enable);
            note_field("read_data", rsp_payload.read_data, want.read_data);
            note_field("read_valid", rsp_payload.read_valid, want.read_valid);
            note_field("read_last", rsp_payload.read_last, want.read_last);
            note_field("done_res", rsp_payload.done_res, want.done_res);
            note_field("status", rsp_payload.status, want.status);
            note_field("busy_res", rsp_payload.busy_res, want.busy_res);
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
